FILE: rtl/bscs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bscs_pkg;

  localparam int DEF_MAX_DIMS    = 4;
  localparam int DEF_COORD_WIDTH = 16;

  localparam int DC_W           = 3;
  localparam int SIZE_W         = 17;
  localparam int PD_W           = 3;
  localparam int BP_W           = 32;
  localparam int NUM_SIZE_REGS  = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int OUT_COORD_W    = 16;
  localparam int NUM_OUT_COORDS = 4;

  // coordinate plus carry, both below 2^32
  localparam int SUM_W = 33;

  localparam logic [DC_W-1:0]   RST_DIM_COUNT      = DC_W'(2);
  localparam logic [SIZE_W-1:0] RST_SIZE           = SIZE_W'(1);
  localparam logic [PD_W-1:0]   RST_PROCESSING_DIM = '0;
  localparam logic [BP_W-1:0]   RST_BLOCK_PIXELS   = BP_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_COUNT      = 3'd0,
    CFG_SIZE_DIM0      = 3'd1,
    CFG_SIZE_DIM1      = 3'd2,
    CFG_SIZE_DIM2      = 3'd3,
    CFG_SIZE_DIM3      = 3'd4,
    CFG_PROCESSING_DIM = 3'd5,
    CFG_BLOCK_PIXELS   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [DC_W-1:0]                        dim_count;
    logic [NUM_SIZE_REGS-1:0][SIZE_W-1:0]   size;
    logic [PD_W-1:0]                        processing_dim;
    logic [BP_W-1:0]                        block_pixels;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic set_flag;
    logic init;
    logic skip;
    logic fast;
    logic div_start;
    logic div_step;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic flag;
    logic bp_zero;
    logic fd_out;
    logic carry_zero;
    logic dim_active;
    logic dim_skip;
    logic fits;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/bscs_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module bscs_cfg
  import bscs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_count      <= RST_DIM_COUNT;
      for (int k = 0; k < NUM_SIZE_REGS; k++) begin
        cfg_r.size[k] <= RST_SIZE;
      end
      cfg_r.processing_dim <= RST_PROCESSING_DIM;
      cfg_r.block_pixels   <= RST_BLOCK_PIXELS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DIM_COUNT:      cfg_r.dim_count      <= cfg_data[DC_W-1:0];
        CFG_SIZE_DIM0:      cfg_r.size[0]        <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_DIM1:      cfg_r.size[1]        <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_DIM2:      cfg_r.size[2]        <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_DIM3:      cfg_r.size[3]        <= cfg_data[SIZE_W-1:0];
        CFG_PROCESSING_DIM: cfg_r.processing_dim <= cfg_data[PD_W-1:0];
        CFG_BLOCK_PIXELS:   cfg_r.block_pixels   <= cfg_data[BP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/bscs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bscs_dp
  import bscs_pkg::*;
#(
  parameter int MAX_DIMS    = DEF_MAX_DIMS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  output logic [OUT_COORD_W-1:0]      out_coord [NUM_OUT_COORDS],
  output logic                        out_past_end
);

  localparam int EW    = COORD_WIDTH + 1;
  localparam int TW    = EW + 1;
  localparam int CMPW  = (EW > SIZE_W) ? EW : SIZE_W;
  localparam int DCW   = $clog2(MAX_DIMS + 1);
  localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNT_W = $clog2(SUM_W);

  logic [COORD_WIDTH-1:0] coord_r [MAX_DIMS];
  logic [COORD_WIDTH-1:0] next_r  [MAX_DIMS];
  logic                   flag_r;
  logic [BP_W-1:0]        carry_r;
  logic [DCW-1:0]         dim_r;
  logic [SUM_W-1:0]       div_q_r;
  logic [EW-1:0]          div_rem_r;
  logic [CNT_W-1:0]       div_cnt_r;
  logic [OUT_COORD_W-1:0] out_coord_r [NUM_OUT_COORDS];
  logic                   out_past_end_r;

  logic [DCW-1:0]         nd;
  logic [DCW-1:0]         fd;
  logic [IDX_W-1:0]       dim_idx;
  logic [SIZE_W-1:0]      size_sel;
  logic                   size_hit;
  logic [CMPW-1:0]        size_x;
  logic [CMPW-1:0]        cap_x;
  logic [CMPW-1:0]        ext_x;
  logic [EW-1:0]          ext;
  logic [COORD_WIDTH-1:0] cur;
  logic [COORD_WIDTH-1:0] cur_c;
  logic [SUM_W-1:0]       sum;
  logic [TW-1:0]          trial;
  logic                   ge;
  logic [EW-1:0]          rem_nxt;
  logic [SUM_W-1:0]       q_nxt;
  logic                   div_last;
  logic [DCW-1:0]         dim_inc;
  logic [OUT_COORD_W-1:0] out_src [NUM_OUT_COORDS];

  assign nd = (int'(cfg.dim_count) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(cfg.dim_count);
  assign fd = (cfg.processing_dim == '0) ? DCW'(1) : '0;
  assign dim_idx = dim_r[IDX_W-1:0];
  assign dim_inc = DCW'(dim_r + DCW'(1));

  // extent of the current dimension
  always_comb begin
    size_sel = '0;
    size_hit = 1'b0;
    for (int k = 0; k < NUM_SIZE_REGS; k++) begin
      if (int'(dim_r) == k) begin
        size_sel = cfg.size[k];
        size_hit = 1'b1;
      end
    end
    size_x = CMPW'(size_sel);
    cap_x  = CMPW'(1) << COORD_WIDTH;
    if (!size_hit || size_x == '0) begin
      ext_x = CMPW'(1);
    end else if (size_x > cap_x) begin
      ext_x = cap_x;
    end else begin
      ext_x = size_x;
    end
    ext = EW'(ext_x);
  end

  assign cur   = next_r[dim_idx];
  assign cur_c = ({1'b0, cur} >= ext) ? COORD_WIDTH'(ext - EW'(1)) : cur;
  assign sum   = SUM_W'(cur_c) + SUM_W'(carry_r);

  // restoring divider, one quotient bit per cycle
  assign trial    = {div_rem_r, div_q_r[SUM_W-1]};
  assign ge       = trial >= TW'(ext);
  assign rem_nxt  = ge ? EW'(trial - TW'(ext)) : EW'(trial);
  assign q_nxt    = {div_q_r[SUM_W-2:0], ge};
  assign div_last = div_cnt_r == CNT_W'(SUM_W - 1);

  always_comb begin
    status            = '0;
    status.flag       = flag_r;
    status.bp_zero    = cfg.block_pixels == '0;
    status.fd_out     = fd >= nd;
    status.carry_zero = carry_r == '0;
    status.dim_active = dim_r < nd;
    status.dim_skip   = int'(dim_r) == int'(cfg.processing_dim);
    status.fits       = sum < SUM_W'(ext);
    status.div_last   = div_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        coord_r[k] <= '0;
      end
      flag_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        for (int k = 0; k < MAX_DIMS; k++) begin
          coord_r[k] <= '0;
        end
        flag_r <= 1'b0;
      end
      if (cmd.set_flag) begin
        flag_r <= 1'b1;
      end
      if (cmd.commit) begin
        for (int k = 0; k < MAX_DIMS; k++) begin
          coord_r[k] <= next_r[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        next_r[k] <= coord_r[k];
      end
      carry_r <= cfg.block_pixels;
      dim_r   <= fd;
    end
    if (cmd.skip) begin
      dim_r <= dim_inc;
    end
    if (cmd.fast) begin
      next_r[dim_idx] <= sum[COORD_WIDTH-1:0];
      carry_r         <= '0;
      dim_r           <= dim_inc;
    end
    if (cmd.div_start) begin
      div_q_r   <= sum;
      div_rem_r <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      div_q_r   <= q_nxt;
      div_rem_r <= rem_nxt;
      div_cnt_r <= CNT_W'(div_cnt_r + CNT_W'(1));
      if (div_last) begin
        next_r[dim_idx] <= rem_nxt[COORD_WIDTH-1:0];
        carry_r         <= q_nxt[BP_W-1:0];
        dim_r           <= dim_inc;
      end
    end
    if (cmd.load_out) begin
      out_coord_r    <= out_src;
      out_past_end_r <= flag_r;
    end
  end

  for (genvar j = 0; j < NUM_OUT_COORDS; j++) begin : g_out
    if (j < MAX_DIMS) begin : g_used
      assign out_src[j] = (DCW'(j) < nd) ? OUT_COORD_W'(coord_r[j]) : '0;
    end else begin : g_unused
      assign out_src[j] = '0;
    end
    assign out_coord[j] = out_coord_r[j];
  end

  assign out_past_end = out_past_end_r;

endmodule

`default_nettype wire

FILE: rtl/bscs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bscs_ctrl
  import bscs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic    in_first_block,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority if (in_first_block) begin
            cmd.clear = 1'b1;
            state_nxt = S_FINISH;
          end else if (status.flag || status.bp_zero) begin
            state_nxt = S_FINISH;
          end else if (status.fd_out) begin
            cmd.set_flag = 1'b1;
            state_nxt    = S_FINISH;
          end else begin
            cmd.init  = 1'b1;
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        priority if (status.carry_zero) begin
          cmd.commit = 1'b1;
          state_nxt  = S_FINISH;
        end else if (!status.dim_active) begin
          cmd.set_flag = 1'b1;
          state_nxt    = S_FINISH;
        end else if (status.dim_skip) begin
          cmd.skip = 1'b1;
        end else if (status.fits) begin
          cmd.fast = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_STEP;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while one is in flight");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && status.div_last) |=> (state_r == S_STEP))
    else $error("divider did not hand back to step");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result loaded but not shown");

  a_commit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !status.flag)
    else $error("commit while overrun held");

endmodule

`default_nettype wire

FILE: rtl/block_start_coordinate_stepper_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  ports                                   handshake
// in       in_first_block                          in_valid / in_ready
// out      out_coord_0..3, out_past_end            out_valid / out_ready
// cfg      cfg_index, cfg_data                     cfg_wr_en, no wait
//
// one beat in flight at a time; a restart or a no-op advance goes from idle straight to finish
// an advance loads a working copy, walks the dimensions touched by the carry and
// runs the bit-serial divider for each dimension whose sum does not fit its extent
// the next beat is taken while the previous result waits in the output register
// synchronous active-low reset gives the origin and the register defaults

module block_start_coordinate_stepper_core
  import bscs_pkg::*;
#(
  parameter int MAX_DIMS    = DEF_MAX_DIMS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_first_block,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [OUT_COORD_W-1:0]      out_coord_0,
  output logic [OUT_COORD_W-1:0]      out_coord_1,
  output logic [OUT_COORD_W-1:0]      out_coord_2,
  output logic [OUT_COORD_W-1:0]      out_coord_3,
  output logic                        out_past_end,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                   cfg;
  cmd_t                   cmd;
  status_t                status;
  logic [OUT_COORD_W-1:0] out_coord [NUM_OUT_COORDS];

  bscs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bscs_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_first_block (in_first_block),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .cmd            (cmd)
  );

  bscs_dp #(
    .MAX_DIMS    (MAX_DIMS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .out_coord    (out_coord),
    .out_past_end (out_past_end)
  );

  assign out_coord_0 = out_coord[0];
  assign out_coord_1 = out_coord[1];
  assign out_coord_2 = out_coord[2];
  assign out_coord_3 = out_coord[3];

endmodule

`default_nettype wire
